@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. They compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `ASSERT_AT(lbl, clk, rst_n, !(cond), msg)
`else
`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

@@ sv/est_pkg.sv @@
// ----------------------------------------------------------------------------
// Endpoint set table package
// Types, request kind codes and controller types shared by the table's files.
// ----------------------------------------------------------------------------
package est_pkg;

    localparam int EST_TABLE_DEPTH = 16;

    typedef logic [1:0]  t_kind;
    typedef logic [31:0] t_ip;
    typedef logic [15:0] t_port;
    typedef logic [4:0]  t_entry_count;

    // Request kind codes. The unused code behaves as a lookup.
    localparam t_kind KIND_LOOKUP = 2'd0;
    localparam t_kind KIND_INSERT = 2'd1;
    localparam t_kind KIND_REMOVE = 2'd2;

    typedef struct packed {
        t_ip   addr;
        t_port port;
    } t_endpoint;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;    // capture the request and restart the scan
        logic rd_en;   // read the next slot
        logic commit;  // apply the update and register the result
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic last_slot;  // the slot being read is the last one
        logic out_free;   // the result register can take a new result
    } t_status;

endpackage

@@ sv/est_if.sv @@
// ----------------------------------------------------------------------------
// Endpoint set table channels
// Valid/ready channels for requests and for results.
// ----------------------------------------------------------------------------
interface est_req_if import est_pkg::*; ();
    logic  valid;
    logic  ready;
    t_kind kind;
    t_ip   ip_address;
    t_port port_number;

    modport source(output valid, kind, ip_address, port_number, input ready);
    modport sink(input valid, kind, ip_address, port_number, output ready);
endinterface

interface est_rsp_if import est_pkg::*; ();
    logic         valid;
    logic         ready;
    logic         was_present;
    logic         full_reject;
    t_entry_count entry_count;

    modport source(output valid, was_present, full_reject, entry_count, input ready);
    modport sink(input valid, was_present, full_reject, entry_count, output ready);
endinterface

@@ sv/est_ctrl.sv @@
// ----------------------------------------------------------------------------
// Endpoint set table controller
// Sequences one request: capture, slot scan, pipeline drain, commit.
// ----------------------------------------------------------------------------
module est_ctrl import est_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.last_slot) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            ST_SCAN: begin
                o_cmd.rd_en = 1'b1;
            end
            ST_DRAIN: begin
                o_cmd = '0;
            end
            ST_COMMIT: begin
                o_cmd.commit = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

@@ sv/est_datapath.sv @@
// ----------------------------------------------------------------------------
// Endpoint set table datapath
// Slot memory, valid bits, entry count, match search and result register.
// ----------------------------------------------------------------------------
module est_datapath import est_pkg::*; #(
    parameter int TABLE_DEPTH = EST_TABLE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cmd         i_cmd,
    output t_status      o_status,
    input  t_kind        i_kind,
    input  t_ip          i_ip_address,
    input  t_port        i_port_number,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output logic         o_was_present,
    output logic         o_full_reject,
    output t_entry_count o_entry_count
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    t_endpoint mem [TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0] r_valid;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;

    t_kind            r_kind;
    t_endpoint        r_key;
    logic [IDX_W-1:0] r_idx;

    logic             r_rd_en;
    logic [IDX_W-1:0] r_rd_idx;
    t_endpoint        r_rd_data;

    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic             r_free_found;
    logic [IDX_W-1:0] r_free_idx;

    logic         r_out_valid;
    logic         r_out_present;
    logic         r_out_reject;
    t_entry_count r_out_count;

    logic slot_match;
    logic do_insert;
    logic do_remove;
    logic reject;

    assign slot_match = r_rd_en && r_valid[r_rd_idx] && (r_rd_data == r_key);
    assign do_insert  = (r_kind == KIND_INSERT) && !r_hit && r_free_found;
    assign reject     = (r_kind == KIND_INSERT) && !r_hit && !r_free_found;
    assign do_remove  = (r_kind == KIND_REMOVE) && r_hit;

    always_comb begin
        n_count = r_count;
        if (do_insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_remove && (r_count != '0)) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && do_insert) begin
            mem[r_free_idx] <= r_key;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[r_idx];
        end
    end

    // Request capture and scan bookkeeping.
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;
        if (i_cmd.load) begin
            r_kind       <= i_kind;
            r_key.addr   <= i_ip_address;
            r_key.port   <= i_port_number;
            r_idx        <= '0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            if (i_cmd.rd_en) begin
                r_idx <= r_idx + IDX_W'(1);
                if (!r_valid[r_idx] && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_idx;
                end
            end
            if (slot_match) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_rd_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_en     <= 1'b0;
            r_valid     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_en <= i_cmd.rd_en;
            if (i_cmd.commit) begin
                r_count <= n_count;
                if (do_insert) begin
                    r_valid[r_free_idx] <= 1'b1;
                end else if (do_remove) begin
                    r_valid[r_hit_idx] <= 1'b0;
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_present <= r_hit;
            r_out_reject  <= reject;
            r_out_count   <= 5'(n_count);
        end
    end

    assign o_status.last_slot = (r_idx == LAST_IDX);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_was_present = r_out_present;
    assign o_full_reject = r_out_reject;
    assign o_entry_count = r_out_count;

endmodule

@@ sv/endpoint_set_table_top.sv @@
// ----------------------------------------------------------------------------
// Endpoint set table: lookup, insert and remove on a bounded set of endpoints.
// A result is registered at commit, after the slot scan and the drain; commit waits
// for a free result register. A new request is taken only in idle, after the last one
// is committed. The scan reads the slot memory one entry per cycle through one port.
// Reset empties the table at once (valid bits and count); slot memory is not swept.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module endpoint_set_table_top import est_pkg::*; #(
    parameter int TABLE_DEPTH = EST_TABLE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    est_req_if.sink   i_req,
    est_rsp_if.source o_rsp
);

    // The controller walks each request through four phases. In idle it is
    // ready for a request transfer and captures the request. In scan it reads
    // one slot per cycle; the datapath compares each registered slot against
    // the request key and notes the lowest free slot from the valid bits. The
    // drain phase lets the compare of the last slot land. In commit the table
    // is updated and the result is written into the result register, which
    // waits until any earlier result has been taken by a transfer.

    t_cmd    cmd;
    t_status status;

    est_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    est_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_kind        (i_req.kind),
        .i_ip_address  (i_req.ip_address),
        .i_port_number (i_req.port_number),
        .o_out_valid   (o_rsp.valid),
        .i_out_ready   (o_rsp.ready),
        .o_was_present (o_rsp.was_present),
        .o_full_reject (o_rsp.full_reject),
        .o_entry_count (o_rsp.entry_count)
    );

    // A request transfer starts a scan, so the next cycle must not take another.
    `ASSERT_AT(a_busy_after_req, i_clk, i_rst_n, (i_req.valid && i_req.ready) |=> !i_req.ready, "request taken while a scan is running")

    // A refused insert means the endpoint was absent.
    `ASSERT_NEVER(a_reject_absent, i_clk, i_rst_n, o_rsp.valid && o_rsp.full_reject && o_rsp.was_present, "insert refused for an endpoint already present")

    // A refused insert happens only with every slot in use.
    `ASSERT_AT(a_reject_full, i_clk, i_rst_n, (o_rsp.valid && o_rsp.full_reject) |-> (o_rsp.entry_count == 5'(TABLE_DEPTH)), "insert refused while a slot was free")

endmodule
